// File: src/macp_pkg.sv
// Package for the MAC address text parser.
// Holds the parse state and result types, character constants and the hex digit decoder.
// Has no dependencies.
package macp_pkg;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [2:0] LastGroup = 3'd5;
  localparam logic [1:0] MaxDigits = 2'd2;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  typedef struct packed {
    logic [2:0]  group_index;
    logic [1:0]  digit_count;
    logic [7:0]  group_value;
    logic [39:0] leading_bytes;
    logic        decided;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    group_index:   3'd0,
    digit_count:   2'd0,
    group_value:   8'd0,
    leading_bytes: 40'd0,
    decided:       1'b1
  };

  typedef struct packed {
    logic        valid;
    logic [47:0] mac;
    logic        status;
  } parse_result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] off;
    d.valid = 1'b0;
    d.value = 4'd0;
    off     = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      off     = c - 8'h30;
      d.valid = 1'b1;
      d.value = off[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      off     = c - 8'h37;
      d.valid = 1'b1;
      d.value = off[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      off     = c - 8'h57;
      d.valid = 1'b1;
      d.value = off[3:0];
    end
    return d;
  endfunction

endpackage

// File: src/macp_if.sv
// Valid/ready channel interfaces for the MAC address text parser.
// Depends on nothing; the payload widths are fixed by the text and address formats.
interface macp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       start_req;

  modport source (output valid, output text_byte, output start_req, input ready);
  modport sink   (input valid, input text_byte, input start_req, output ready);
endinterface

interface macp_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] mac;
  logic        status;

  modport source (output valid, output mac, output status, input ready);
  modport sink   (input valid, input mac, input status, output ready);
endinterface

// File: src/macp_step.sv
// Next-state and result logic for one text byte of the MAC address parser.
// Depends on macp_pkg.
module macp_step (
  input  logic [7:0]            text_byte_i,
  input  logic                  start_req_i,
  input  macp_pkg::parse_state_t state_i,
  output macp_pkg::parse_state_t state_o,
  output macp_pkg::parse_result_t result_o
);
  import macp_pkg::*;

  parse_state_t cur;
  hex_digit_t   dig;

  always_comb begin
    cur = state_i;
    if (start_req_i) begin
      cur = '0;
    end
    dig      = hex_digit(text_byte_i);
    state_o  = cur;
    result_o = '{valid: 1'b0, mac: 48'd0, status: StatusOk};

    if (!start_req_i && state_i.decided) begin
      state_o = state_i;
    end else if (dig.valid) begin
      if (cur.digit_count >= MaxDigits) begin
        state_o.decided = 1'b1;
        result_o = '{valid: 1'b1, mac: 48'd0, status: StatusErr};
      end else begin
        state_o.group_value = {cur.group_value[3:0], dig.value};
        state_o.digit_count = cur.digit_count + 2'd1;
      end
    end else if (cur.digit_count == 2'd0) begin
      state_o.decided = 1'b1;
      result_o = '{valid: 1'b1, mac: 48'd0, status: StatusErr};
    end else if (cur.group_index < LastGroup) begin
      if (text_byte_i != CharColon) begin
        state_o.decided = 1'b1;
        result_o = '{valid: 1'b1, mac: 48'd0, status: StatusErr};
      end else begin
        state_o.leading_bytes = {cur.leading_bytes[31:0], cur.group_value};
        state_o.group_index   = cur.group_index + 3'd1;
        state_o.digit_count   = 2'd0;
        state_o.group_value   = 8'd0;
      end
    end else if (text_byte_i <= CharSpace) begin
      state_o.decided = 1'b1;
      result_o = '{valid: 1'b1, mac: {cur.leading_bytes, cur.group_value}, status: StatusOk};
    end else begin
      state_o.decided = 1'b1;
      result_o = '{valid: 1'b1, mac: 48'd0, status: StatusErr};
    end
  end

endmodule

// File: src/mac_address_text_parser.sv
// Top level of the MAC address text parser: input register, parse state, result register.
// Depends on macp_pkg, macp_in_if, macp_out_if and macp_step.
//
//   Channel  Dir  Payload                      Transaction
//   in_i     in   text_byte[7:0], start_req    one character of the address text
//   out_o    out  mac[47:0], status            one parse decision (success or error)
//
// A character is registered when it is accepted and parsed from there into the result
// register; one character per cycle while the result register is empty or being emptied.
// Reset leaves the parser waiting for a character with start_req set.
// A stalled result holds its register; characters that give no result keep flowing
// as long as the result register is empty or being emptied.
module mac_address_text_parser (
  input logic          clk_i,
  input logic          rst_ni,
  macp_in_if.sink      in_i,
  macp_out_if.source   out_o
);
  import macp_pkg::*;

  logic          s1_valid_q;
  logic [7:0]    s1_byte_q;
  logic          s1_start_q;
  parse_state_t  state_q;
  parse_state_t  state_d;
  parse_result_t res;
  logic          out_valid_q;
  logic [47:0]   out_mac_q;
  logic          out_status_q;
  logic          slot_free;
  logic          s1_take;

  assign slot_free = !out_valid_q || out_o.ready;
  assign s1_take   = s1_valid_q && slot_free;
  assign in_i.ready = !s1_valid_q || slot_free;

  macp_step u_step (
    .text_byte_i (s1_byte_q),
    .start_req_i (s1_start_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q  <= in_i.text_byte;
      s1_start_q <= in_i.start_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (s1_take) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= s1_valid_q && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && res.valid) begin
      out_mac_q    <= res.mac;
      out_status_q <= res.status;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.mac    = out_mac_q;
  assign out_o.status = out_status_q;

  a_err_mac_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == StatusErr) |-> out_mac_q == 48'd0)
    else $error("Error result carries a nonzero address.");

  a_result_decides : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_take && res.valid) |=> state_q.decided)
    else $error("Parser did not settle after giving a result.");

  a_digit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.digit_count <= MaxDigits)
    else $error("Digit count exceeds two.");

  a_group_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.group_index <= LastGroup)
    else $error("Group index beyond the last group.");

endmodule
